FILE: sv/insertion_sort_engine_assert.svh
// Assertion macros for the insertion sort engine.
// Used by the top level; needs nothing else.
`ifndef INSERTION_SORT_ENGINE_ASSERT_SVH
`define INSERTION_SORT_ENGINE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define ISE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("insertion sort engine check failed");

// Next-cycle implication, disabled during reset
`define ISE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("insertion sort engine check failed");

`endif

FILE: sv/ise_pkg.sv
// Shared types and constants for the insertion sort engine.
// No dependencies.
package ise_pkg;

   localparam int VALUE_W = 32;

   typedef logic signed [VALUE_W-1:0] value_type;

   // Per-cycle command broadcast to every cell
   typedef struct packed {
      logic insert;   // place the new value into the chain
      logic shift;    // move every entry one cell towards the output
   } cell_ctrl_type;

endpackage

FILE: sv/ise_if.sv
// Handshake channels of the insertion sort engine.
// Depends on ise_pkg.
interface ise_req_if
   import ise_pkg::*;
();
   logic      valid;
   logic      ready;
   value_type value;
   logic      last;

   modport source (output valid, output value, output last, input ready);
   modport sink   (input valid, input value, input last, output ready);
endinterface

interface ise_rsp_if
   import ise_pkg::*;
();
   logic      valid;
   logic      ready;
   value_type value_res;
   logic      last_res;
   logic      overflow;

   modport source (output valid, output value_res, output last_res, output overflow,
                   input ready);
   modport sink   (input valid, input value_res, input last_res, input overflow,
                   output ready);
endinterface

FILE: sv/ise_cell.sv
// One compare-and-shift cell of the sorting chain.
// Depends on ise_pkg.
module ise_cell
   import ise_pkg::*;
(
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  value_type     new_value,
   input  logic          occ,        // this cell holds a live entry
   input  logic          left_occ,   // left neighbour holds a live entry
   input  logic          left_gt,    // left neighbour moves up on this insert
   input  value_type     left_val,
   input  value_type     right_val,
   output value_type     val,
   output logic          gt
);

   value_type val_ff;
   value_type val_in;

   assign val = val_ff;
   // strictly greater only: equal entries keep arrival order
   assign gt  = occ && (val_ff > new_value);

   always_comb begin
      val_in = val_ff;
      if (ctrl.shift) begin
         val_in = right_val;
      end else if (ctrl.insert) begin
         if (!(occ && !gt) && left_occ) begin
            val_in = left_gt ? left_val : new_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

endmodule

FILE: sv/insertion_sort_engine.sv
// Insertion sort engine: collects signed 32-bit values into a sorted chain of
// DEPTH cells, one value per cycle while not draining, and on the item marked
// last transfers the whole run out in ascending order. Depends on ise_pkg, ise_if, ise_cell.
//
// During collection each input transfer broadcasts the new value to every
// cell, each cell compares it with its own entry and the cells holding
// strictly greater entries pass them one place up in that same cycle, so equal
// values stay in arrival order. Once the last item is in, the chain drains
// from cell 0, one result per cycle while rsp ready is high; no input is taken
// during the drain. The final result carries last_res. Values arriving while
// all DEPTH cells are occupied are dropped, and every result of that run then
// carries overflow. After the final result the count and overflow flag clear
// and the next run may start in the following cycle.
module insertion_sort_engine
   import ise_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input logic      clock,
   input logic      reset,
   ise_req_if.sink   req_chan,
   ise_rsp_if.source rsp_chan
);

`include "insertion_sort_engine_assert.svh"

   localparam int CNT_W = $clog2(DEPTH + 1);

   // ---------------------------------------------------------------------
   // Control state
   // ---------------------------------------------------------------------
   logic [CNT_W-1:0] count_ff, count_in;      // live entries in the chain
   logic             drain_ff, drain_in;      // emitting the run
   logic             dropped_ff, dropped_in;  // a value of this run was lost

   logic req_xfer;
   logic rsp_xfer;
   logic full;

   cell_ctrl_type ctrl;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign req_xfer = req_chan.valid && req_chan.ready;
   assign rsp_xfer = rsp_chan.valid && rsp_chan.ready;

   assign req_chan.ready = !drain_ff;

   assign ctrl.insert = req_xfer && !full;
   assign ctrl.shift  = rsp_xfer;

   // ---------------------------------------------------------------------
   // Cell chain
   // ---------------------------------------------------------------------
   value_type vals [DEPTH];
   logic      gts  [DEPTH];
   logic      occs [DEPTH];

   genvar gi;
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_cell
         assign occs[gi] = (CNT_W'(gi) < count_ff);

         if (gi == 0) begin : g_first
            ise_cell u_cell (
               .clock     (clock),
               .ctrl      (ctrl),
               .new_value (req_chan.value),
               .occ       (occs[gi]),
               .left_occ  (1'b1),
               .left_gt   (1'b0),
               .left_val  ('0),
               .right_val ((DEPTH > 1) ? vals[(DEPTH > 1) ? 1 : 0] : '0),
               .val       (vals[gi]),
               .gt        (gts[gi])
            );
         end else if (gi == DEPTH - 1) begin : g_tail
            ise_cell u_cell (
               .clock     (clock),
               .ctrl      (ctrl),
               .new_value (req_chan.value),
               .occ       (occs[gi]),
               .left_occ  (occs[gi-1]),
               .left_gt   (gts[gi-1]),
               .left_val  (vals[gi-1]),
               .right_val ('0),
               .val       (vals[gi]),
               .gt        (gts[gi])
            );
         end else begin : g_mid
            ise_cell u_cell (
               .clock     (clock),
               .ctrl      (ctrl),
               .new_value (req_chan.value),
               .occ       (occs[gi]),
               .left_occ  (occs[gi-1]),
               .left_gt   (gts[gi-1]),
               .left_val  (vals[gi-1]),
               .right_val (vals[gi+1]),
               .val       (vals[gi]),
               .gt        (gts[gi])
            );
         end
      end
   endgenerate

   // ---------------------------------------------------------------------
   // Result channel: cell 0 is the output register during the drain
   // ---------------------------------------------------------------------
   assign rsp_chan.valid     = drain_ff;
   assign rsp_chan.value_res = vals[0];
   assign rsp_chan.last_res  = (count_ff == CNT_W'(1));
   assign rsp_chan.overflow  = dropped_ff;

   // ---------------------------------------------------------------------
   // Next state
   // ---------------------------------------------------------------------
   always_comb begin
      count_in   = count_ff;
      drain_in   = drain_ff;
      dropped_in = dropped_ff;
      if (req_xfer) begin
         if (full) begin
            dropped_in = 1'b1;
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
         if (req_chan.last) begin
            drain_in = 1'b1;
         end
      end
      if (rsp_xfer) begin
         count_in = count_ff - CNT_W'(1);
         if (count_ff == CNT_W'(1)) begin
            // final transfer of the run
            drain_in   = 1'b0;
            dropped_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         drain_ff   <= 1'b0;
         dropped_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         drain_ff   <= drain_in;
         dropped_ff <= dropped_in;
      end
   end

   // ---------------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------------
   `ISE_ASSERT_NOW(a_drain_nonempty, clock, reset, drain_ff, count_ff != '0)
   `ISE_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH))
   `ISE_ASSERT_NEXT(a_last_starts_drain, clock, reset, req_xfer && req_chan.last,
                    drain_ff)
   `ISE_ASSERT_NEXT(a_run_ends_clean, clock, reset, rsp_xfer && rsp_chan.last_res,
                    !drain_ff && count_ff == '0 && !dropped_ff)

endmodule
